[src/tsc_pkg.sv]
// Shared types, constants and the register update function of the triad stream cipher.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tsc_pkg;

    // Default number of warm-up updates after a start request
    localparam int unsigned WARMUP_ROUNDS_DEF = 1024;

    // Configuration port geometry
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = CFG_IDX_W'(3);

    // Request kinds carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Updates done per cycle in the fast path (one data byte)
    localparam int unsigned UPD_PER_BYTE = 8;

    // Register lengths in bits
    localparam int unsigned A_LEN = 80;
    localparam int unsigned B_LEN = 88;
    localparam int unsigned C_LEN = 88;

    // Key and nonce material
    typedef struct packed {
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [63:0] nonce_lo;
        logic [31:0] nonce_hi;
    } tsc_keys_t;

    // Cipher state; bit p of each vector is position p (feedback enters at 0)
    typedef struct packed {
        logic [A_LEN-1:0] a;
        logic [B_LEN-1:0] b;
        logic [C_LEN-1:0] c;
    } tsc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // load state from key, nonce and constant
        logic step8;    // eight updates
        logic step1;    // one update
        logic capture;  // register the XORed data byte
    } tsc_cmd_t;

    // A byte lands with its MSB at the lowest position of its slot
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // Keystream bit of the current state
    function automatic logic tsc_keybit(input tsc_state_t s);
        logic t1, t2, t3;
        t1 = s.a[68] ^ s.a[79] ^ (s.b[85] & s.c[85]);
        t2 = s.b[64] ^ s.b[87];
        t3 = s.c[68] ^ s.c[87];
        return t1 ^ t2 ^ t3;
    endfunction

    // One register update
    function automatic tsc_state_t tsc_update(input tsc_state_t s);
        tsc_state_t n;
        logic t1, t2, t3;
        t1 = s.a[68] ^ s.a[79] ^ (s.b[85] & s.c[85]) ^ (s.a[73] & s.a[79]) ^ s.b[66];
        t2 = s.b[64] ^ s.b[87] ^ (s.b[65] & s.b[87]) ^ s.c[84];
        t3 = s.c[68] ^ s.c[87] ^ (s.c[77] & s.c[87]) ^ s.a[74];
        n.a = {s.a[A_LEN-2:0], t3};
        n.b = {s.b[B_LEN-2:0], t1};
        n.c = {s.c[C_LEN-2:0], t2};
        return n;
    endfunction

endpackage

[src/tsc_cfg_regs.sv]
// Key and nonce configuration registers of the triad stream cipher.
// Depends on tsc_pkg for the register indexes and the key struct.
`timescale 1ns / 1ps

module tsc_cfg_regs import tsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tsc_keys_t             keys
);

    tsc_keys_t keys_reg, keys_next;

    assign cfg_ready = 1'b1;
    assign keys      = keys_reg;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        keys_next = keys_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_LO:   keys_next.key_lo   = cfg_data;
                CFG_KEY_HI:   keys_next.key_hi   = cfg_data;
                CFG_NONCE_LO: keys_next.nonce_lo = cfg_data;
                CFG_NONCE_HI: keys_next.nonce_hi = cfg_data[31:0];
                default:      keys_next          = keys_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= '0;
        end else begin
            keys_reg <= keys_next;
        end
    end

endmodule

[src/tsc_datapath.sv]
// Datapath: the three feedback shift registers, eight-update unrolled step and result register.
// Depends on tsc_pkg for the state type, the update function and the command struct.
`timescale 1ns / 1ps

module tsc_datapath import tsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  tsc_cmd_t  cmd,
    input  tsc_keys_t keys,
    input  logic [7:0] data_byte,
    output logic [7:0] result_byte
);

    tsc_state_t st_reg, st_next;
    tsc_state_t st_load, st_one, st_eight;
    logic [7:0] ks;
    logic [7:0] result_reg, result_next;

    // Initial state from key, nonce and the fixed pattern
    always_comb begin
        st_load.a[ 0 +: 8] = rev8(keys.nonce_lo[ 0 +: 8]);
        st_load.a[ 8 +: 8] = rev8(keys.key_lo[32 +: 8]);
        st_load.a[16 +: 8] = 8'hFF;
        st_load.a[24 +: 8] = rev8(keys.key_lo[24 +: 8]);
        st_load.a[32 +: 8] = 8'hFF;
        st_load.a[40 +: 8] = rev8(keys.key_lo[16 +: 8]);
        st_load.a[48 +: 8] = 8'hFF;
        st_load.a[56 +: 8] = rev8(keys.key_lo[ 8 +: 8]);
        st_load.a[64 +: 8] = rev8(8'hFE);
        st_load.a[72 +: 8] = rev8(keys.key_lo[ 0 +: 8]);
        // second register: nonce bytes 11 down to 1
        st_load.b[ 0 +: 8] = rev8(keys.nonce_hi[24 +: 8]);
        st_load.b[ 8 +: 8] = rev8(keys.nonce_hi[16 +: 8]);
        st_load.b[16 +: 8] = rev8(keys.nonce_hi[ 8 +: 8]);
        st_load.b[24 +: 8] = rev8(keys.nonce_hi[ 0 +: 8]);
        for (int k = 4; k < 11; k++) begin
            st_load.b[8*k +: 8] = rev8(keys.nonce_lo[8*(11-k) +: 8]);
        end
        // third register: key bytes 15 down to 5
        for (int k = 0; k < 8; k++) begin
            st_load.c[8*k +: 8] = rev8(keys.key_hi[8*(7-k) +: 8]);
        end
        for (int k = 8; k < 11; k++) begin
            st_load.c[8*k +: 8] = rev8(keys.key_lo[8*(15-k) +: 8]);
        end
    end

    // Eight updates in one cycle; taps sit above the bits shifted in this cycle
    always_comb begin
        tsc_state_t s;
        s      = st_reg;
        st_one = tsc_update(st_reg);
        for (int u = 0; u < UPD_PER_BYTE; u++) begin
            ks[7-u] = tsc_keybit(s);
            s       = tsc_update(s);
        end
        st_eight = s;
    end

    // State register select
    always_comb begin
        priority if (cmd.load) begin
            st_next = st_load;
        end else if (cmd.step8) begin
            st_next = st_eight;
        end else if (cmd.step1) begin
            st_next = st_one;
        end else begin
            st_next = st_reg;
        end
    end

    assign result_next = cmd.capture ? (data_byte ^ ks) : result_reg;
    assign result_byte = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

    // Result holds no control state
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

[src/tsc_ctrl.sv]
// Controller: stream handshakes, warm-up round counter and datapath commands.
// Depends on tsc_pkg for request codes and the command struct.
`timescale 1ns / 1ps

module tsc_ctrl import tsc_pkg::*; #(
    parameter int unsigned WARMUP_ROUNDS = WARMUP_ROUNDS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_cmd,
    output logic     m_tvalid,
    input  logic     m_tready,
    output tsc_cmd_t cmd
);

    localparam int unsigned CNT_W = $clog2(WARMUP_ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WARM = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] rounds_reg, rounds_next;
    logic [31:0]      rounds_left;
    logic             big_step;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    // Eight updates a cycle while at least eight remain, then single updates
    assign big_step    = (32'(rounds_reg) >= 32'(UPD_PER_BYTE));
    assign rounds_left = 32'(rounds_reg) - (big_step ? 32'(UPD_PER_BYTE) : 32'd1);

    always_comb begin
        state_next  = state_reg;
        rounds_next = rounds_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_cmd == CMD_START) begin
                        cmd.load    = 1'b1;
                        rounds_next = CNT_W'(WARMUP_ROUNDS);
                        state_next  = ST_WARM;
                    end else begin
                        cmd.step8   = 1'b1;
                        cmd.capture = 1'b1;
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_WARM: begin
                cmd.step8   = big_step;
                cmd.step1   = !big_step;
                rounds_next = rounds_left[CNT_W-1:0];
                if (rounds_left == 32'd0) begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rounds_reg <= '0;
        end else begin
            state_reg  <= state_next;
            rounds_reg <= rounds_next;
        end
    end

endmodule

[src/triad_stream_cipher_byte.sv]
// Top level of the triad stream cipher: configuration registers, controller and datapath.
// Depends on tsc_pkg, tsc_cfg_regs, tsc_ctrl and tsc_datapath.
`timescale 1ns / 1ps

// Byte-wide stream cipher over three nonlinear feedback shift registers (80, 88, 88 bits).
// Write key and nonce through the cfg port while idle, then send a start request
// (tuser = 0): it loads the registers and runs WARMUP_ROUNDS updates, eight per cycle
// and single updates for the remainder, and yields no result. A data request (tuser = 1)
// XORs the byte with eight keystream bits, MSB first, through the unrolled update logic;
// the result sits in the output register and the next request is taken the cycle after
// it is consumed, so only one byte is in flight at a time. Encrypt and decrypt are
// identical.
module triad_stream_cipher_byte import tsc_pkg::*; #(
    parameter int unsigned WARMUP_ROUNDS = WARMUP_ROUNDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] command
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [7:0] result_byte
);

    tsc_keys_t keys;
    tsc_cmd_t  cmd;

    tsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    tsc_ctrl #(
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tsc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .keys        (keys),
        .data_byte   (s_tdata),
        .result_byte (m_tdata)
    );

endmodule

[src/tsc_checker.sv]
// Port-level checks of the triad stream cipher and the bind that attaches them.
// Depends on tsc_pkg for request codes.
`timescale 1ns / 1ps

module tsc_checker import tsc_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [0:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata
);

    // One request in flight: never ready for input while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // A data request shows its result on the next cycle
    a_data_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_DATA) |=> m_tvalid)
        else $error("data request produced no result");

    // A start request yields no result and blocks input while warming up
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_START) |=> (!m_tvalid && !s_tready))
        else $error("start request did not enter warm-up");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Once the result is taken the block is ready again
    a_ready_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("not ready after result was taken");

endmodule

bind triad_stream_cipher_byte tsc_checker u_tsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_triad_stream_cipher_byte.sv]
// Self-checking testbench for triad_stream_cipher_byte: bursty requests, a stalling sink,
// and a bit-level model of the three shift registers that predicts every result byte.
// Depends on tsc_pkg and the triad_stream_cipher_byte RTL.
`timescale 1ns / 1ps

module tb_triad_stream_cipher_byte;
    import tsc_pkg::*;

    localparam int unsigned WARMUP      = WARMUP_ROUNDS_DEF;
    // cycles a start request keeps the block busy after acceptance
    localparam int unsigned BUSY_CYCLES = WARMUP / 8 + WARMUP % 8;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 200;

    // Tracks key, nonce and cipher state; holds the result bytes still owed by the block
    class triad_cipher_tracker;
        bit [79:0]   reg_a;
        bit [87:0]   reg_b;
        bit [87:0]   reg_c;
        bit [63:0]   key_lo;
        bit [63:0]   key_hi;
        bit [63:0]   nonce_lo;
        bit [31:0]   nonce_hi;
        bit [7:0]    pending_bytes[$];
        int unsigned failures;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_KEY_LO:   key_lo = value;
                CFG_KEY_HI:   key_hi = value;
                CFG_NONCE_LO: nonce_lo = value;
                CFG_NONCE_HI: nonce_hi = value[31:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] key_at(int unsigned i);
            return (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
        endfunction

        function bit [7:0] nonce_at(int unsigned i);
            return (i < 8) ? nonce_lo[8*i +: 8] : nonce_hi[8*(i-8) +: 8];
        endfunction

        // byte k sits at positions 8k..8k+7 with its MSB at the lowest position
        function bit [7:0] mirror(bit [7:0] v);
            bit [7:0] r;
            for (int i = 0; i < 8; i++) begin
                r[i] = v[7-i];
            end
            return r;
        endfunction

        // one register update; returns the keystream bit taken before the shift
        function bit clock_once();
            bit t1, t2, t3, z;
            t1 = reg_a[68] ^ reg_a[79] ^ (reg_b[85] & reg_c[85]);
            t2 = reg_b[64] ^ reg_b[87];
            t3 = reg_c[68] ^ reg_c[87];
            z  = t1 ^ t2 ^ t3;
            t1 ^= (reg_a[73] & reg_a[79]) ^ reg_b[66];
            t2 ^= (reg_b[65] & reg_b[87]) ^ reg_c[84];
            t3 ^= (reg_c[77] & reg_c[87]) ^ reg_a[74];
            reg_a = {reg_a[78:0], t3};
            reg_b = {reg_b[86:0], t1};
            reg_c = {reg_c[86:0], t2};
            return z;
        endfunction

        function void load_and_warm();
            bit [7:0] a_bytes[10];
            a_bytes = '{nonce_at(0), key_at(4), 8'hFF, key_at(3), 8'hFF,
                        key_at(2), 8'hFF, key_at(1), 8'hFE, key_at(0)};
            for (int k = 0; k < 10; k++) begin
                reg_a[8*k +: 8] = mirror(a_bytes[k]);
            end
            for (int k = 0; k < 11; k++) begin
                reg_b[8*k +: 8] = mirror(nonce_at(11 - k));
                reg_c[8*k +: 8] = mirror(key_at(15 - k));
            end
            for (int r = 0; r < WARMUP; r++) begin
                void'(clock_once());
            end
        endfunction

        function void accept_request(logic cmd, logic [7:0] text);
            bit [7:0] out;
            if (cmd == CMD_START) begin
                load_and_warm();
            end else begin
                for (int j = 7; j >= 0; j--) begin
                    out[j] = text[j] ^ clock_once();
                end
                pending_bytes.push_back(out);
            end
        endfunction

        function void check_byte(logic [7:0] got);
            bit [7:0] want;
            if (pending_bytes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result byte %02h, nothing pending", got);
            end else begin
                want = pending_bytes.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display("result_byte mismatch: expected %02h, got %02h", want, got);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic [0:0]            s_tuser;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // [7:0] result_byte

    triad_cipher_tracker tracker = new();

    int unsigned burst_left  = 0;
    int unsigned sink_left   = 0;
    int unsigned sink_mode   = 0;
    int unsigned idle_cycles = 0;

    triad_stream_cipher_byte #(.WARMUP_ROUNDS(WARMUP)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Request and result monitors
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.accept_request(s_tuser[0], s_tdata);
        if (aresetn && m_tvalid && m_tready)
            tracker.check_byte(m_tdata);
    end

    // Sink stall pattern: segments of always-ready, mostly-ready and mostly-stalled
    always @(posedge aclk) begin
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 2);
            sink_left <= $urandom_range(8, 120);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb_triad_stream_cipher_byte: FAIL");
        $finish;
    end

    // One request, sent inside a burst; a new burst may start after a gap
    task automatic send_request(input logic cmd, input logic [7:0] text);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= text;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Stop sending, let the monitor note the last request, let all results out,
    // then let a pending warm-up finish
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.pending_bytes.size() != 0) @(posedge aclk);
        repeat (BUSY_CYCLES + 8) @(posedge aclk);
    endtask

    // cfg_valid stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, value);
    endtask

    // All four registers, then a write to an unused index that must be ignored
    task automatic configure(input logic [63:0] k_lo, input logic [63:0] k_hi,
                             input logic [63:0] n_lo, input logic [63:0] n_hi);
        write_reg(CFG_KEY_LO, k_lo);
        write_reg(CFG_KEY_HI, k_hi);
        write_reg(CFG_NONCE_LO, n_lo);
        write_reg(CFG_NONCE_HI, n_hi);
        write_reg(CFG_IDX_W'($urandom_range(CFG_NONCE_HI + 1, (1 << CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom};
            default: return ($urandom_range(0, 1) != 0) ? 64'hAAAA_AAAA_AAAA_AAAA
                                                        : 64'h5555_5555_5555_5555;
        endcase
    endfunction

    // Stimulus
    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_START;
        m_tready  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // data on the all-zero reset state, then a start whose data byte is ignored
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_DATA, 8'h80);
        send_request(CMD_DATA, 8'h01);
        send_request(CMD_START, 8'hFF);
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_DATA, 8'h55);
        send_request(CMD_DATA, 8'hAA);
        drain();

        // all-ones key and nonce, back-to-back starts
        configure('1, '1, '1, '1);
        send_request(CMD_START, 8'h00);
        send_request(CMD_START, 8'h5A);
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_DATA, 8'h0F);
        send_request(CMD_DATA, 8'hF0);
        drain();

        // all-zero key and nonce
        configure('0, '0, '0, '0);
        send_request(CMD_START, 8'h00);
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'hFF);
        drain();

        // random settings: mostly a start followed by a data stream, some restarts
        for (int p = 0; p < PHASES; p++) begin
            configure(pick_word(), pick_word(), pick_word(), pick_word());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ((i == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 24) == 0)
                    send_request(CMD_START, 8'($urandom_range(0, 255)));
                else
                    send_request(CMD_DATA, 8'($urandom_range(0, 255)));
            end
            drain();
        end

        if (tracker.failures == 0 && tracker.pending_bytes.size() == 0)
            $display("tb_triad_stream_cipher_byte: PASS");
        else
            $display("tb_triad_stream_cipher_byte: FAIL");
        $finish;
    end

endmodule

[triad_stream_cipher_byte.f]
src/tsc_pkg.sv
src/tsc_cfg_regs.sv
src/tsc_datapath.sv
src/tsc_ctrl.sv
src/triad_stream_cipher_byte.sv
src/tsc_checker.sv
dv/tb_triad_stream_cipher_byte.sv
